/* rtl/core/ssim_pkg.sv */
// Shared types, constants and the direction table for the serpentine scroll index mapper.
// Used by ssim_map, ssim_scroll_state and serpentine_scroll_index_mapper; depends on nothing.
package ssim_pkg;

    // The matrix side must be a power of two: rows and columns split off the index by bits.
    localparam int SIDE    = 16;
    localparam int SIDE_W  = $clog2(SIDE);
    localparam int NUM_PIX = SIDE * SIDE;
    localparam int PERIOD  = 2 * SIDE;
    localparam int IDX_W   = 8;
    localparam int DIR_W   = 4;
    localparam int OFF_W   = 8;
    localparam int SUM_W   = OFF_W + 1;

    localparam logic signed [OFF_W-1:0] OFF_START = OFF_W'(-SIDE);

    typedef enum logic [DIR_W-1:0] {
        DIR_STILL = 4'd0,
        DIR_S     = 4'd1,
        DIR_SW    = 4'd2,
        DIR_WEST  = 4'd3,
        DIR_NW    = 4'd4,
        DIR_N     = 4'd5,
        DIR_NE    = 4'd6,
        DIR_E     = 4'd7,
        DIR_SE    = 4'd8
    } dir_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic                    has_entered;
        logic                    restart_pending;
    } scroll_state_t;

    // A moving axis also starts one side length outside the view.
    typedef struct packed {
        logic scrolling;
        logic move_x;
        logic move_y;
        logic flip_x;
        logic flip_y;
    } dir_info_t;

    function automatic dir_info_t dir_lookup(logic [DIR_W-1:0] d);
        dir_info_t info;
        info = '0;
        case (d)
            DIR_S:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b0, move_y: 1'b1, flip_x: 1'b0, flip_y: 1'b0};
            end
            DIR_SW:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b1, move_y: 1'b1, flip_x: 1'b0, flip_y: 1'b0};
            end
            DIR_WEST:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b1, move_y: 1'b0, flip_x: 1'b0, flip_y: 1'b0};
            end
            DIR_NW:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b1, move_y: 1'b1, flip_x: 1'b0, flip_y: 1'b1};
            end
            DIR_N:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b0, move_y: 1'b1, flip_x: 1'b0, flip_y: 1'b1};
            end
            DIR_NE:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b1, move_y: 1'b1, flip_x: 1'b1, flip_y: 1'b1};
            end
            DIR_E:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b1, move_y: 1'b0, flip_x: 1'b1, flip_y: 1'b0};
            end
            DIR_SE:
            begin
                info = '{scrolling: 1'b1, move_x: 1'b1, move_y: 1'b1, flip_x: 1'b1, flip_y: 1'b0};
            end
            default:
            begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

/* rtl/core/ssim_map.sv */
// Combinational index mapping and next scroll state for one pixel index.
// Depends on ssim_pkg.
module ssim_map
    import ssim_pkg::*;
(
    input  logic [DIR_W-1:0] dir,
    input  scroll_state_t    st,
    input  logic [IDX_W-1:0] pixel_index,
    output logic [IDX_W-1:0] source_index,
    output logic             in_view,
    output scroll_state_t    st_next
);

    dir_info_t               info;
    logic                    in_range;
    logic                    frame_end;
    logic [SIDE_W-1:0]       row;
    logic [SIDE_W-1:0]       col;
    logic [SIDE_W-1:0]       px;
    logic [SIDE_W-1:0]       ux;
    logic [SIDE_W-1:0]       uy;
    logic signed [OFF_W-1:0] base_x;
    logic signed [OFF_W-1:0] base_y;
    logic                    base_entered;
    logic signed [SUM_W-1:0] vx;
    logic signed [SUM_W-1:0] vy;
    logic                    visible;
    logic [SIDE_W-1:0]       wx;
    logic [SIDE_W-1:0]       wy;
    logic [SIDE_W-1:0]       src_col;
    logic [IDX_W-1:0]        src_idx;
    logic signed [OFF_W-1:0] nx;
    logic signed [OFF_W-1:0] ny;
    logic                    entered_n;

    always_comb
    begin
        info      = dir_lookup(dir);
        in_range  = int'(pixel_index) < NUM_PIX;
        frame_end = int'(pixel_index) == NUM_PIX - 1;

        row = SIDE_W'(pixel_index >> SIDE_W);
        col = pixel_index[SIDE_W-1:0];
        px  = row[0] ? ~col : col;
        ux  = info.flip_x ? ~px : px;
        uy  = info.flip_y ? ~row : row;

        // A pending restart is applied before this pixel is mapped.
        if (st.restart_pending)
        begin
            base_x       = info.move_x ? OFF_START : '0;
            base_y       = info.move_y ? OFF_START : '0;
            base_entered = 1'b0;
        end
        else
        begin
            base_x       = st.off_x;
            base_y       = st.off_y;
            base_entered = st.has_entered;
        end

        vx = signed'(SUM_W'(ux)) + SUM_W'(base_x);
        vy = signed'(SUM_W'(uy)) + SUM_W'(base_y);
        if (base_entered && vx >= PERIOD)
        begin
            vx = vx - SUM_W'(PERIOD);
        end
        if (base_entered && vy >= PERIOD)
        begin
            vy = vy - SUM_W'(PERIOD);
        end

        visible = (vx >= 0) && (vx < SIDE) && (vy >= 0) && (vy < SIDE);
        wx      = info.flip_x ? ~vx[SIDE_W-1:0] : vx[SIDE_W-1:0];
        wy      = info.flip_y ? ~vy[SIDE_W-1:0] : vy[SIDE_W-1:0];
        src_col = wy[0] ? ~wx : wx;
        src_idx = IDX_W'({wy, src_col});

        if (!in_range)
        begin
            in_view      = 1'b0;
            source_index = '0;
        end
        else if (!info.scrolling)
        begin
            in_view      = 1'b1;
            source_index = pixel_index;
        end
        else
        begin
            in_view      = visible;
            source_index = visible ? src_idx : '0;
        end

        // Offsets step once per frame, on the last pixel index.
        nx = base_x + OFF_W'(frame_end && info.move_x);
        ny = base_y + OFF_W'(frame_end && info.move_y);
        entered_n = base_entered || (frame_end && nx >= 0 && ny >= 0);
        if (frame_end && entered_n && nx >= PERIOD)
        begin
            nx = nx - OFF_W'(PERIOD);
        end
        if (frame_end && entered_n && ny >= PERIOD)
        begin
            ny = ny - OFF_W'(PERIOD);
        end

        st_next = st;
        if (in_range && info.scrolling)
        begin
            st_next.off_x           = nx;
            st_next.off_y           = ny;
            st_next.has_entered     = entered_n;
            st_next.restart_pending = 1'b0;
        end
    end

endmodule

/* rtl/core/ssim_scroll_state.sv */
// Direction register and scroll state (offsets, entered and restart flags).
// Depends on ssim_pkg.
module ssim_scroll_state
    import ssim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIR_W-1:0] cfg_data,
    input  logic             commit,
    input  scroll_state_t    st_next,
    output logic [DIR_W-1:0] dir,
    output scroll_state_t    st
);

    logic [DIR_W-1:0] dir_reg;
    logic [DIR_W-1:0] dir_next;
    scroll_state_t    st_reg;
    scroll_state_t    st_state_next;

    always_comb
    begin
        dir_next      = dir_reg;
        st_state_next = st_reg;
        if (commit)
        begin
            st_state_next = st_next;
        end
        // A new direction code restarts the scroll; a write never cancels a restart.
        if (cfg_we)
        begin
            dir_next = cfg_data;
            if (cfg_data != dir_reg)
            begin
                st_state_next.restart_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg                <= DIR_STILL;
            st_reg.off_x           <= '0;
            st_reg.off_y           <= '0;
            st_reg.has_entered     <= 1'b0;
            st_reg.restart_pending <= 1'b1;
        end
        else
        begin
            dir_reg <= dir_next;
            st_reg  <= st_state_next;
        end
    end

    assign dir = dir_reg;
    assign st  = st_reg;

endmodule

/* rtl/core/serpentine_scroll_index_mapper.sv */
// Top level of the serpentine scroll index mapper: input register, mapping, result register.
// Depends on ssim_pkg, ssim_map and ssim_scroll_state.
//
//   channel   signals                                    direction
//   input     in_valid, in_ready, pixel_index            into block
//   result    out_valid, out_ready, source_index, in_view out of block
//   config    cfg_valid, cfg_ready, scroll_direction     into block
//
// One pixel index is taken every cycle unless the result side stalls; the result is registered.
// The mapping and the scroll state update sit between the input and result registers.
// Reset sets the direction to still, clears the offsets and marks a restart pending.
// A stalled result holds the input register, and input is refused only when both are full
// and the result is not being taken.
// Configuration is always ready.
module serpentine_scroll_index_mapper
    import ssim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] pixel_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] source_index,
    output logic             in_view,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DIR_W-1:0] scroll_direction
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [IDX_W-1:0] src_reg;
    logic             view_reg;
    logic             advance;
    logic             commit;
    logic             cfg_we;
    logic [DIR_W-1:0] dir;
    scroll_state_t    st;
    scroll_state_t    st_next;
    logic [IDX_W-1:0] map_src;
    logic             map_view;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign commit    = s1_valid_reg && advance;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_idx_reg <= pixel_index;
        end
        if (commit)
        begin
            src_reg  <= map_src;
            view_reg <= map_view;
        end
    end

    ssim_scroll_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (scroll_direction),
        .commit   (commit),
        .st_next  (st_next),
        .dir      (dir),
        .st       (st)
    );

    ssim_map u_map (
        .dir          (dir),
        .st           (st),
        .pixel_index  (s1_idx_reg),
        .source_index (map_src),
        .in_view      (map_view),
        .st_next      (st_next)
    );

    assign out_valid    = out_valid_reg;
    assign source_index = src_reg;
    assign in_view      = view_reg;

`ifndef NO_ASSERTIONS
    // A different direction code always leaves a restart pending.
    a_restart_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && scroll_direction != dir) |=> st.restart_pending)
        else $error("direction change did not mark a restart");

    // Once entered, both offsets stay inside one wrap period.
    a_entered_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        st.has_entered |-> (st.off_x >= 0 && st.off_x < PERIOD
                            && st.off_y >= 0 && st.off_y < PERIOD))
        else $error("offsets outside the wrap period after entering");

    // A held input item keeps its index while the result side stalls.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("input register changed while stalled");

    // The scroll state moves only when an item passes through the mapping or a configuration write arrives.
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!commit && !cfg_we) |=> $stable(st))
        else $error("scroll state changed without a transfer");
`endif

endmodule
